// ===== src/firdb_pkg.sv =====
// Shared constants, command codes and control structs for the FIR filter with
// double-buffered taps. No dependencies; used by every module of the block.
package firdb_pkg;

  // Filter length and derived widths
  localparam int unsigned NumTaps  = 64;
  localparam int unsigned AddrW    = (NumTaps > 1) ? $clog2(NumTaps) : 1;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TapIdxW  = 6;
  localparam int unsigned ProdW    = 2 * SampleW;
  localparam int unsigned AccW     = ProdW + AddrW + 1;
  localparam int unsigned FracW    = SampleW - 1;

  // Item operation codes
  localparam logic OpFilter   = 1'b0;
  localparam logic OpTapWrite = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic sample_start;  // sample transfer: store sample, clear accumulator
    logic tap_write;     // tap transfer: write shadow bank, swap on commit
    logic issue;         // read one history sample and one tap
    logic load_out;      // round, saturate and register the result
  } firdb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_tap;      // current issue is the final tap
    logic pipe_busy;     // products still in flight
  } firdb_sts_t;

endpackage

// ===== src/firdb_dp.sv =====
// Datapath of the FIR filter: history and tap bank memories, the
// multiply-accumulate pipeline and the output register. Uses firdb_pkg.
module firdb_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  firdb_pkg::firdb_cmd_t                cmd_i,
  output firdb_pkg::firdb_sts_t                sts_o,
  input  logic signed [firdb_pkg::SampleW-1:0] sample_in_i,
  input  logic        [firdb_pkg::TapIdxW-1:0] tap_index_i,
  input  logic signed [firdb_pkg::SampleW-1:0] tap_value_i,
  input  logic                                 commit_i,
  output logic signed [firdb_pkg::SampleW-1:0] sample_out_o
);

  localparam int unsigned QW = firdb_pkg::AccW - firdb_pkg::FracW;

  // Memories and their per-entry valid bits (invalid reads as zero)
  logic signed [firdb_pkg::SampleW-1:0] hist_mem  [firdb_pkg::NumTaps];
  logic signed [firdb_pkg::SampleW-1:0] bank0_mem [firdb_pkg::NumTaps];
  logic signed [firdb_pkg::SampleW-1:0] bank1_mem [firdb_pkg::NumTaps];
  logic [firdb_pkg::NumTaps-1:0]        hist_vld_q, bank0_vld_q, bank1_vld_q;

  // Pointers and bank select (0: bank0 is active)
  logic [firdb_pkg::AddrW-1:0] wr_pos_q, wr_next, rd_ptr_q, tap_k_q, tap_addr;
  logic                        sel_q;
  logic                        tap_in_range;

  // Pipeline registers
  logic signed [firdb_pkg::SampleW-1:0] hist_rd_q, bank0_rd_q, bank1_rd_q;
  logic                                 hist_rv_q, bank0_rv_q, bank1_rv_q;
  logic                                 s1_q, s2_q;
  logic signed [firdb_pkg::SampleW-1:0] hist_val, tap_val;
  logic signed [firdb_pkg::ProdW-1:0]   prod_q;
  logic signed [firdb_pkg::AccW-1:0]    acc_q, rnd;
  logic signed [QW-1:0]                 quot;
  logic                                 pos_ovf, neg_ovf;
  logic signed [firdb_pkg::SampleW-1:0] sat_val, sample_out_q;

  // Next history slot with wrap
  assign wr_next = (wr_pos_q == firdb_pkg::AddrW'(firdb_pkg::NumTaps - 1)) ?
                   '0 : wr_pos_q + firdb_pkg::AddrW'(1);

  assign tap_in_range = 32'(tap_index_i) < 32'(firdb_pkg::NumTaps);
  assign tap_addr     = firdb_pkg::AddrW'(tap_index_i);

  // Control registers: pointers, tap counter, bank select, pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      rd_ptr_q <= '0;
      tap_k_q  <= '0;
      sel_q    <= 1'b0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
    end else begin
      s1_q <= cmd_i.issue;
      s2_q <= s1_q;
      if (cmd_i.sample_start) begin
        wr_pos_q <= wr_next;
        rd_ptr_q <= wr_next;
        tap_k_q  <= '0;
      end else if (cmd_i.issue) begin
        rd_ptr_q <= (rd_ptr_q == '0) ?
                    firdb_pkg::AddrW'(firdb_pkg::NumTaps - 1) :
                    rd_ptr_q - firdb_pkg::AddrW'(1);
        tap_k_q  <= tap_k_q + firdb_pkg::AddrW'(1);
      end
      if (cmd_i.tap_write && commit_i) begin
        sel_q <= ~sel_q;
      end
    end
  end

  // Valid bits: reset marks every entry as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q  <= '0;
      bank0_vld_q <= '0;
      bank1_vld_q <= '0;
    end else begin
      if (cmd_i.sample_start) begin
        hist_vld_q[wr_next] <= 1'b1;
      end
      if (cmd_i.tap_write && tap_in_range) begin
        if (sel_q) begin
          bank0_vld_q[tap_addr] <= 1'b1;
        end else begin
          bank1_vld_q[tap_addr] <= 1'b1;
        end
      end
    end
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_start) begin
      hist_mem[wr_next] <= sample_in_i;
    end
    if (cmd_i.issue) begin
      hist_rd_q <= hist_mem[rd_ptr_q];
      hist_rv_q <= hist_vld_q[rd_ptr_q];
    end
  end

  // Tap bank 0: written while it is the shadow bank
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_write && tap_in_range && sel_q) begin
      bank0_mem[tap_addr] <= tap_value_i;
    end
    if (cmd_i.issue) begin
      bank0_rd_q <= bank0_mem[tap_k_q];
      bank0_rv_q <= bank0_vld_q[tap_k_q];
    end
  end

  // Tap bank 1: written while it is the shadow bank
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_write && tap_in_range && !sel_q) begin
      bank1_mem[tap_addr] <= tap_value_i;
    end
    if (cmd_i.issue) begin
      bank1_rd_q <= bank1_mem[tap_k_q];
      bank1_rv_q <= bank1_vld_q[tap_k_q];
    end
  end

  // Select active tap, blank entries never written
  always_comb begin
    hist_val = hist_rv_q ? hist_rd_q : '0;
    if (sel_q) begin
      tap_val = bank1_rv_q ? bank1_rd_q : '0;
    end else begin
      tap_val = bank0_rv_q ? bank0_rd_q : '0;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_q <= hist_val * tap_val;
    end
    if (cmd_i.sample_start) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + firdb_pkg::AccW'(prod_q);
    end
  end

  // Round half up to Q1.15 and saturate
  always_comb begin
    rnd     = acc_q + firdb_pkg::AccW'(1 << (firdb_pkg::FracW - 1));
    quot    = rnd[firdb_pkg::AccW-1:firdb_pkg::FracW];
    pos_ovf = !quot[QW-1] && (|quot[QW-2:firdb_pkg::FracW]);
    neg_ovf = quot[QW-1] && !(&quot[QW-2:firdb_pkg::FracW]);
    if (pos_ovf) begin
      sat_val = {1'b0, {(firdb_pkg::SampleW-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_val = {1'b1, {(firdb_pkg::SampleW-1){1'b0}}};
    end else begin
      sat_val = quot[firdb_pkg::SampleW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_q <= sat_val;
    end
  end

  assign sample_out_o   = sample_out_q;
  assign sts_o.last_tap  = (tap_k_q == firdb_pkg::AddrW'(firdb_pkg::NumTaps - 1));
  assign sts_o.pipe_busy = s1_q || s2_q;

endmodule

// ===== src/firdb_ctrl.sv =====
// Controller of the FIR filter: input and output handshakes and the sequencer
// that steps the datapath through one pass over the taps. Uses firdb_pkg.
module firdb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output firdb_pkg::firdb_cmd_t cmd_o,
  input  firdb_pkg::firdb_sts_t sts_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one sample: issue every tap, drain the pipeline, load result
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        // input is never stalled here, so valid alone marks a transfer
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == firdb_pkg::OpFilter) begin
            cmd_o.sample_start = 1'b1;
            state_d            = StRun;
          end else begin
            cmd_o.tap_write = 1'b1;
          end
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_tap) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!sts_i.pipe_busy && out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/fir_filter_double_buffered_taps.sv =====
// Top level of the FIR filter with double-buffered taps.
// Instantiates firdb_ctrl and firdb_dp; uses firdb_pkg.
//
// A 64-tap direct-form FIR filter on Q1.15 samples with one shared multiplier.
// A sample transfer (op 0) shifts the sample into the history and yields one
// rounded, saturated Q1.15 output; the newest sample meets tap 0. A tap
// transfer (op 1) writes one coefficient into the shadow bank and, with commit
// set, swaps shadow and active banks after the write, so a whole tap set takes
// effect at once; it yields no output. History and both banks read as zero
// from reset, with no clearing pass. A tap transfer is taken in idle and leaves
// the block idle, so the next item is taken without a stall. A sample transfer
// keeps the input stalled while the block does one multiply-accumulate per tap
// through the single multiplier and the single read port of each memory, then
// drains the pipeline and loads the output. The load waits, and the stall
// lasts longer, while an earlier result is still held by the receiver.
// The output register lets the next item be taken while a result waits.
module fir_filter_double_buffered_taps (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic signed [firdb_pkg::SampleW-1:0] sample_in_i,
  input  logic        [firdb_pkg::TapIdxW-1:0] tap_index_i,
  input  logic signed [firdb_pkg::SampleW-1:0] tap_value_i,
  input  logic                                 commit_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [firdb_pkg::SampleW-1:0] sample_out_o
);

  firdb_pkg::firdb_cmd_t cmd;
  firdb_pkg::firdb_sts_t sts;

  // Sequencer and handshakes
  firdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Memories and multiply-accumulate
  firdb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (sample_in_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .commit_i     (commit_i),
    .sample_out_o (sample_out_o)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for fir_filter_double_buffered_taps: directed and random
// transfers, with a bit-exact filter predictor, random input gaps and random output stalls.
// Depends on firdb_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 10;
  localparam longint      LimitCycles = 1000000;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned RandItems   = 2000;

  typedef logic signed [firdb_pkg::SampleW-1:0] q15_t;

  typedef struct {
    logic                          op;
    q15_t                          sample;
    logic [firdb_pkg::TapIdxW-1:0] idx;
    q15_t                          tap;
    logic                          commit;
    bit                            wait_drain;  // hold back until every result has come
  } fir_item_t;

  // Clock, reset and block inputs, all known from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          op_i        = firdb_pkg::OpFilter;
  q15_t                          sample_in_i = '0;
  logic [firdb_pkg::TapIdxW-1:0] tap_index_i = '0;
  q15_t                          tap_value_i = '0;
  logic                          commit_i    = 1'b0;
  logic                          out_stall_i = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  q15_t                          sample_out_o;

  // Predictor state: history[0] is the newest sample
  q15_t history [firdb_pkg::NumTaps];
  q15_t act_taps [firdb_pkg::NumTaps];
  q15_t shd_taps [firdb_pkg::NumTaps];

  fir_item_t   pending_items[$];
  q15_t        expected_out[$];
  int unsigned n_items      = 0;
  int unsigned errors       = 0;
  int unsigned rx_count     = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  logic        in_accepted  = 1'b0;
  logic        out_accepted = 1'b0;

  fir_filter_double_buffered_taps dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .sample_in_i  (sample_in_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .commit_i     (commit_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // Shift the sample in, accumulate exactly, round half up and saturate
  function automatic q15_t filter_sample(q15_t s);
    longint acc;
    longint q;
    acc = 0;
    for (int k = firdb_pkg::NumTaps - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = s;
    for (int k = 0; k < firdb_pkg::NumTaps; k++) begin
      acc += longint'(history[k]) * longint'(act_taps[k]);
    end
    q = (acc + 64'sd16384) >>> firdb_pkg::FracW;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q15_t'(q);
  endfunction

  // Write one shadow tap, then swap the banks on commit
  function automatic void load_shadow_tap(logic [firdb_pkg::TapIdxW-1:0] idx, q15_t v,
                                          logic c);
    q15_t t;
    if (idx < firdb_pkg::NumTaps) shd_taps[idx] = v;
    if (c) begin
      for (int k = 0; k < firdb_pkg::NumTaps; k++) begin
        t           = act_taps[k];
        act_taps[k] = shd_taps[k];
        shd_taps[k] = t;
      end
    end
  endfunction

  // Mostly small taps so that outputs do not always saturate
  function automatic q15_t draw_tap();
    if ($urandom_range(0, 3) == 0) return q15_t'($urandom);
    return q15_t'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  task automatic push_sample(q15_t s, bit drain);
    fir_item_t it;
    it.op         = firdb_pkg::OpFilter;
    it.sample     = s;
    it.idx        = firdb_pkg::TapIdxW'($urandom);
    it.tap        = q15_t'($urandom);
    it.commit     = 1'($urandom);
    it.wait_drain = drain;
    pending_items.push_back(it);
    n_items++;
  endtask

  task automatic push_tap(logic [firdb_pkg::TapIdxW-1:0] idx, q15_t v, logic c);
    fir_item_t it;
    it.op         = firdb_pkg::OpTapWrite;
    it.sample     = q15_t'($urandom);
    it.idx        = idx;
    it.tap        = v;
    it.commit     = c;
    it.wait_drain = 1'b0;
    pending_items.push_back(it);
    n_items++;
  endtask

  initial begin
    for (int k = 0; k < firdb_pkg::NumTaps; k++) begin
      history[k]  = '0;
      act_taps[k] = '0;
      shd_taps[k] = '0;
    end
  end

  // Monitor: check each output transfer, then predict each input transfer
  always @(posedge clk_i) begin
    q15_t want;
    if (!rst_ni) begin
      in_accepted  <= 1'b0;
      out_accepted <= 1'b0;
    end else begin
      in_accepted  <= in_valid_i && !in_stall_o;
      out_accepted <= (out_valid_o === 1'b1) && !out_stall_i;
      if ((out_valid_o === 1'b1) && !out_stall_i) begin
        rx_count++;
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected sample_out, expected none, got %0d", $time, sample_out_o);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (sample_out_o !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, sample_out_o);
            errors++;
          end
        end
      end
      if (in_valid_i && (in_stall_o === 1'b0)) begin
        if (op_i == firdb_pkg::OpFilter) expected_out.push_back(filter_sample(sample_in_i));
        else load_shadow_tap(tap_index_i, tap_value_i, commit_i);
      end
    end
  end

  // Driver: present queued items at the falling edge, with random gaps
  always @(negedge clk_i) begin
    fir_item_t it;
    logic vld;
    if (rst_ni) begin
      vld = in_valid_i;
      if (in_valid_i && in_accepted) begin
        vld    = 1'b0;
        tx_gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if ($urandom_range(0, 63) == 0) tx_idle_on = ~tx_idle_on;
      end
      if (!vld) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_drain && expected_out.size() != 0)) begin
          it          = pending_items.pop_front();
          op_i        <= it.op;
          sample_in_i <= it.sample;
          tap_index_i <= it.idx;
          tap_value_i <= it.tap;
          commit_i    <= it.commit;
          vld         = 1'b1;
        end
      end
      in_valid_i <= vld;
    end
  end

  // Receiver: stall a random while after each transfer, twice for a long stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_accepted) begin
        rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
        if (rx_count == 150 || rx_count == 600) rx_wait = LongHold;
        if ($urandom_range(0, 63) == 0) rx_idle_on = ~rx_idle_on;
      end
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned drain_cnt;
    logic        last_commit;

    // Directed: zero taps give zero at both sample extremes
    push_sample(q15_t'(32767), 1'b0);
    push_sample(q15_t'(-32768), 1'b0);
    // Shadow write has no effect until the commit
    push_tap(6'd0, q15_t'(1), 1'b0);
    push_sample(q15_t'(16384), 1'b0);
    push_tap(6'd63, q15_t'(-32768), 1'b1);
    // Exact halves round toward plus infinity
    push_sample(q15_t'(16384), 1'b0);
    push_sample(q15_t'(-16384), 1'b0);
    // Positive then negative saturation
    push_tap(6'd0, q15_t'(-32768), 1'b0);
    push_tap(6'd1, q15_t'(-32768), 1'b1);
    push_sample(q15_t'(-32768), 1'b0);
    push_sample(q15_t'(-32768), 1'b0);
    push_sample(q15_t'(32767), 1'b0);
    push_sample(q15_t'(32767), 1'b0);
    // Old active set returns as shadow on the next commit
    push_tap(6'd2, q15_t'(32767), 1'b1);
    push_sample(q15_t'(32767), 1'b1);
    push_tap(6'd63, q15_t'(32767), 1'b1);
    push_sample(q15_t'(-1), 1'b0);
    push_sample(q15_t'(0), 1'b1);

    // Random: mostly tap-load sequences followed by runs of samples
    while (n_items < RandItems) begin
      kind = $urandom_range(0, 39);
      if (kind == 0) begin
        // reload the whole bank in order
        for (int k = 0; k < firdb_pkg::NumTaps; k++)
          push_tap(firdb_pkg::TapIdxW'(k), draw_tap(), (k == firdb_pkg::NumTaps - 1));
      end else if (kind < 26) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          last_commit = (k == n - 1) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 9) == 0);
          push_tap(firdb_pkg::TapIdxW'($urandom), draw_tap(), last_commit);
        end
        n = $urandom_range(1, 20);
        for (int k = 0; k < n; k++) push_sample(q15_t'($urandom), 1'b0);
      end else if (kind < 34) begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) push_sample(q15_t'($urandom), 1'b0);
      end else begin
        // noise: single items of either kind
        if ($urandom_range(0, 1) == 0) push_sample(q15_t'($urandom), 1'b0);
        else push_tap(firdb_pkg::TapIdxW'($urandom), q15_t'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 29) == 0) push_sample(q15_t'($urandom), 1'b1);
    end

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    drain_cnt = 0;
    while (expected_out.size() != 0 &&
           drain_cnt < 4 * (firdb_pkg::NumTaps + 8) + LongHold) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    repeat (firdb_pkg::NumTaps + 8) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      $display("%0t: %0d results missing, next expected %0d, got none",
               $time, expected_out.size(), expected_out[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("simulation failed");
    $finish;
  end

endmodule
